FILE: hdl/igd_pkg.sv
// Shared types and constants for the inverted generational distance block.
`timescale 1ns / 1ps
package igd_pkg;

    localparam int unsigned OP_BITS = 2;
    localparam int unsigned VALUE_BITS = 32;
    localparam int unsigned IGD_BITS = 17;
    localparam int unsigned STATUS_BITS = 2;

    typedef enum logic [1:0] {
        OP_ADD_REF  = 2'd0,
        OP_ADD_CAND = 2'd1,
        OP_EVAL     = 2'd2,
        OP_CLR_REF  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY_POP  = 2'd1,
        ST_NO_REF     = 2'd2,
        ST_ZERO_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        op_t                    operation;
        logic [VALUE_BITS-1:0]  cost_value;
        logic [VALUE_BITS-1:0]  emission_value;
    } in_item_t;

    typedef struct packed {
        logic [IGD_BITS-1:0] igd_value;
        status_t             status;
        logic                points_dropped;
    } out_item_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_BND_RD,
        S_BND_UPD,
        S_NRM_RD,
        S_NRM_DIV,
        S_NRM_WR,
        S_NN_RD,
        S_NN_MUL,
        S_NN_ADD,
        S_SQRT,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } state_t;

endpackage

FILE: hdl/inverted_generational_distance.sv
// Inverted generational distance over stored reference and candidate fronts.
// Appends and clears finish when accepted. An evaluate scans all points for the bounds,
// normalizes each point, finds each reference's nearest candidate and its root, divides the
// root sum by the reference count and posts; with no candidates or references it posts at once.
// Throughput: one item at a time; s_ready is low while evaluate runs and its result waits.
// Reset (aresetn, synchronous): counts, overflow flag and control clear.
`timescale 1ns / 1ps
module inverted_generational_distance #(
    parameter int unsigned MAX_REFERENCES = 256,
    parameter int unsigned MAX_CANDIDATES = 256,
    parameter int unsigned OBJECTIVE_BITS = 32,
    parameter int unsigned FRACTION_BITS  = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  igd_pkg::in_item_t    s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output igd_pkg::out_item_t   m_item
);

    localparam int unsigned RA = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int unsigned CA = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int unsigned RC = $clog2(MAX_REFERENCES + 1);
    localparam int unsigned CC = $clog2(MAX_CANDIDATES + 1);
    localparam int unsigned OB = OBJECTIVE_BITS;
    localparam int unsigned DW = (OB > RC) ? OB : RC;   // divisor width
    localparam int unsigned NB = FRACTION_BITS + 1;     // normalized coord
    localparam int unsigned SQ = 2 * NB + 1;            // squared distance
    localparam int unsigned RT = NB + 1;                // root width
    localparam int unsigned SB = RT + RA + 1;           // sum width
    localparam int unsigned SBC = (SB > 6) ? $clog2(SB + 1) : 3;
    localparam int unsigned IGD_W = igd_pkg::IGD_BITS;
    localparam logic [IGD_W-1:0] IGD_MAX = '1;
    localparam logic [IGD_W-1:0] IGD_ONE =
        (FRACTION_BITS < IGD_W) ? IGD_W'(1 << FRACTION_BITS) : IGD_MAX;

    // point stores
    logic [OB-1:0] rc_mem [MAX_REFERENCES];
    logic [OB-1:0] re_mem [MAX_REFERENCES];
    logic [OB-1:0] cc_mem [MAX_CANDIDATES];
    logic [OB-1:0] ce_mem [MAX_CANDIDATES];
    logic [NB-1:0] rnc_mem [MAX_REFERENCES];
    logic [NB-1:0] rne_mem [MAX_REFERENCES];
    logic [NB-1:0] cnc_mem [MAX_CANDIDATES];
    logic [NB-1:0] cne_mem [MAX_CANDIDATES];

    igd_pkg::state_t state_reg, state_next;
    logic [RC-1:0] rcnt_reg, rcnt_next;
    logic [CC-1:0] ccnt_reg, ccnt_next;
    logic ovf_reg, ovf_next;
    logic m_valid_reg, m_valid_next;
    igd_pkg::out_item_t m_item_reg, m_item_next;

    // sequencer indices; side selects reference (0) or candidate (1)
    logic side_reg, side_next;
    logic [RC+CC-1:0] i_reg, i_next;
    logic [CC-1:0] j_reg, j_next;
    logic axis_reg, axis_next;
    logic first_reg, first_next;

    logic [OB-1:0] cmin_reg, cmin_next, cmax_reg, cmax_next;
    logic [OB-1:0] emin_reg, emin_next, emax_reg, emax_next;

    // registered memory reads
    logic [OB-1:0] rd_c_reg, rd_e_reg;
    logic [NB-1:0] rd_nc_reg, rd_ne_reg, rd_rnc_reg, rd_rne_reg;
    logic [RA-1:0] raddr_r;
    logic [CA-1:0] raddr_c;

    // shared datapath registers
    logic [DW:0] acc_reg, acc_next;          // remainder
    logic [DW-1:0] dv_reg, dv_next;          // divisor
    logic [SB-1:0] q_reg, q_next;            // quotient / root / sum
    logic [SBC-1:0] k_reg, k_next;
    logic [NB-1:0] nc_tmp_reg, nc_tmp_next;
    logic [SQ-1:0] sq_a_reg, sq_a_next, sq_b_reg, sq_b_next;
    logic [SQ-1:0] best_reg, best_next;
    logic [SB-1:0] sum_reg, sum_next;
    logic [2*SQ-1:0] x_reg, x_next;          // sqrt remainder, wide
    logic [2*SQ-1:0] rs_reg, rs_next;
    logic wr_norm;

    igd_pkg::in_item_t itm;
    assign itm = s_item;

    logic [OB-1:0] in_c, in_e;
    assign in_c = OB'(itm.cost_value);
    assign in_e = OB'(itm.emission_value);

    assign s_ready = (state_reg == igd_pkg::S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // stores written in clocked blocks
    always_ff @(posedge aclk) begin
        if (s_fire && itm.operation == igd_pkg::OP_ADD_REF && rcnt_reg < RC'(MAX_REFERENCES)) begin
            rc_mem[rcnt_reg[RA-1:0]] <= in_c;
            re_mem[rcnt_reg[RA-1:0]] <= in_e;
        end
        if (s_fire && itm.operation == igd_pkg::OP_ADD_CAND && ccnt_reg < CC'(MAX_CANDIDATES)) begin
            cc_mem[ccnt_reg[CA-1:0]] <= in_c;
            ce_mem[ccnt_reg[CA-1:0]] <= in_e;
        end
        if (wr_norm && !side_reg) begin
            rnc_mem[raddr_r] <= nc_tmp_reg;
            rne_mem[raddr_r] <= q_reg[NB-1:0];
        end
        if (wr_norm && side_reg) begin
            cnc_mem[raddr_c] <= nc_tmp_reg;
            cne_mem[raddr_c] <= q_reg[NB-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!side_next) begin
            rd_c_reg <= rc_mem[i_next[RA-1:0]];
            rd_e_reg <= re_mem[i_next[RA-1:0]];
        end else begin
            rd_c_reg <= cc_mem[i_next[CA-1:0]];
            rd_e_reg <= ce_mem[i_next[CA-1:0]];
        end
        rd_rnc_reg <= rnc_mem[i_next[RA-1:0]];
        rd_rne_reg <= rne_mem[i_next[RA-1:0]];
        rd_nc_reg  <= cnc_mem[j_next[CA-1:0]];
        rd_ne_reg  <= cne_mem[j_next[CA-1:0]];
    end
    assign raddr_r = i_reg[RA-1:0];
    assign raddr_c = i_reg[CA-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= igd_pkg::S_IDLE;
            rcnt_reg    <= '0;
            ccnt_reg    <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rcnt_reg    <= rcnt_next;
            ccnt_reg    <= ccnt_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
        m_item_reg <= m_item_next;
        side_reg <= side_next;   i_reg <= i_next;   j_reg <= j_next;
        axis_reg <= axis_next;   first_reg <= first_next;
        cmin_reg <= cmin_next;   cmax_reg <= cmax_next;
        emin_reg <= emin_next;   emax_reg <= emax_next;
        acc_reg <= acc_next;     dv_reg <= dv_next;   q_reg <= q_next;
        k_reg <= k_next;         nc_tmp_reg <= nc_tmp_next;
        sq_a_reg <= sq_a_next;   sq_b_reg <= sq_b_next;
        best_reg <= best_next;   sum_reg <= sum_next;
        x_reg <= x_next;         rs_reg <= rs_next;
    end

    // normalize helpers for the current axis
    logic [OB-1:0] lo_sel, hi_sel, v_sel, a_clip, d_rng;
    logic [NB-1:0] dc_abs, de_abs;
    logic [DW:0] rem_sh;
    logic [2*SQ-1:0] trial;

    always_comb begin
        lo_sel = axis_reg ? emin_reg : cmin_reg;
        hi_sel = axis_reg ? emax_reg : cmax_reg;
        v_sel  = axis_reg ? rd_e_reg : rd_c_reg;
        d_rng  = hi_sel - lo_sel;
        a_clip = (v_sel > lo_sel) ? v_sel - lo_sel : '0;
        if (a_clip > d_rng) a_clip = d_rng;
        dc_abs = (rd_nc_reg > rd_rnc_reg) ? rd_nc_reg - rd_rnc_reg : rd_rnc_reg - rd_nc_reg;
        de_abs = (rd_ne_reg > rd_rne_reg) ? rd_ne_reg - rd_rne_reg : rd_rne_reg - rd_ne_reg;
        rem_sh = {acc_reg[DW-1:0], 1'b0};
        trial  = rs_reg | ((2*SQ)'(1) << {k_reg, 1'b0});
    end

    always_comb begin
        state_next   = state_reg;
        rcnt_next    = rcnt_reg;
        ccnt_next    = ccnt_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        side_next = side_reg;  i_next = i_reg;  j_next = j_reg;
        axis_next = axis_reg;  first_next = first_reg;
        cmin_next = cmin_reg;  cmax_next = cmax_reg;
        emin_next = emin_reg;  emax_next = emax_reg;
        acc_next = acc_reg;    dv_next = dv_reg;  q_next = q_reg;
        k_next = k_reg;        nc_tmp_next = nc_tmp_reg;
        sq_a_next = sq_a_reg;  sq_b_next = sq_b_reg;
        best_next = best_reg;  sum_next = sum_reg;
        x_next = x_reg;        rs_next = rs_reg;
        wr_norm = 1'b0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            igd_pkg::S_IDLE: begin
                if (s_fire) begin
                    unique case (itm.operation)
                        igd_pkg::OP_ADD_REF: begin
                            if (rcnt_reg < RC'(MAX_REFERENCES)) rcnt_next = rcnt_reg + 1'b1;
                            else ovf_next = 1'b1;
                        end
                        igd_pkg::OP_ADD_CAND: begin
                            if (ccnt_reg < CC'(MAX_CANDIDATES)) ccnt_next = ccnt_reg + 1'b1;
                            else ovf_next = 1'b1;
                        end
                        igd_pkg::OP_CLR_REF: rcnt_next = '0;
                        igd_pkg::OP_EVAL: begin
                            if (ccnt_reg == '0) begin
                                m_item_next.igd_value = IGD_ONE;
                                m_item_next.status = igd_pkg::ST_EMPTY_POP;
                                state_next = igd_pkg::S_OUT;
                            end else if (rcnt_reg == '0) begin
                                m_item_next.igd_value = '0;
                                m_item_next.status = igd_pkg::ST_NO_REF;
                                state_next = igd_pkg::S_OUT;
                            end else begin
                                side_next = 1'b0;
                                i_next = '0;
                                first_next = 1'b1;
                                state_next = igd_pkg::S_BND_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // read point i (address presented via i_next)
            igd_pkg::S_BND_RD: state_next = igd_pkg::S_BND_UPD;
            igd_pkg::S_BND_UPD: begin
                // seed with first ref; extremes are the same as seeding with last
                if (first_reg) begin
                    cmin_next = rd_c_reg; cmax_next = rd_c_reg;
                    emin_next = rd_e_reg; emax_next = rd_e_reg;
                    first_next = 1'b0;
                end else begin
                    if (rd_c_reg < cmin_reg) cmin_next = rd_c_reg;
                    if (rd_c_reg > cmax_reg) cmax_next = rd_c_reg;
                    if (rd_e_reg < emin_reg) emin_next = rd_e_reg;
                    if (rd_e_reg > emax_reg) emax_next = rd_e_reg;
                end
                state_next = igd_pkg::S_BND_RD;
                if (!side_reg && i_reg + 1'b1 == (RC+CC)'(rcnt_reg)) begin
                    side_next = 1'b1; i_next = '0;
                end else if (side_reg && i_reg + 1'b1 == (RC+CC)'(ccnt_reg)) begin
                    side_next = 1'b0; i_next = '0; axis_next = 1'b0;
                    state_next = igd_pkg::S_NRM_RD;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            igd_pkg::S_NRM_RD: begin
                // set up restoring divide for the current axis
                if (hi_sel <= lo_sel) begin
                    acc_next = '0; dv_next = '1; q_next = '0; k_next = '0;
                end else begin
                    acc_next = (a_clip == d_rng) ? '0 : (DW+1)'(a_clip);
                    q_next = (a_clip == d_rng) ? SB'(1) : '0;
                    dv_next = DW'(d_rng);
                    k_next = SBC'(FRACTION_BITS);
                end
                state_next = igd_pkg::S_NRM_DIV;
            end
            igd_pkg::S_NRM_DIV: begin
                if (k_reg == '0) begin
                    if (!axis_reg) begin
                        nc_tmp_next = q_reg[NB-1:0];
                        axis_next = 1'b1;
                        state_next = igd_pkg::S_NRM_RD;
                    end else begin
                        state_next = igd_pkg::S_NRM_WR;
                    end
                end else begin
                    k_next = k_reg - 1'b1;
                    q_next = {q_reg[SB-2:0], 1'b0};
                    acc_next = rem_sh;
                    if (rem_sh >= {1'b0, dv_reg}) begin
                        acc_next = rem_sh - {1'b0, dv_reg};
                        q_next[0] = 1'b1;
                    end
                end
            end
            igd_pkg::S_NRM_WR: begin
                // the next point is read on this edge, so normalize it right away
                wr_norm = 1'b1;
                axis_next = 1'b0;
                state_next = igd_pkg::S_NRM_RD;
                if (!side_reg && i_reg + 1'b1 == (RC+CC)'(rcnt_reg)) begin
                    side_next = 1'b1; i_next = '0;
                end else if (side_reg && i_reg + 1'b1 == (RC+CC)'(ccnt_reg)) begin
                    side_next = 1'b0; i_next = '0; j_next = '0;
                    sum_next = '0; best_next = '1;
                    state_next = igd_pkg::S_NN_RD;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            igd_pkg::S_NN_RD: state_next = igd_pkg::S_NN_MUL;
            igd_pkg::S_NN_MUL: begin
                sq_a_next = SQ'(dc_abs) * SQ'(dc_abs);
                sq_b_next = SQ'(de_abs) * SQ'(de_abs);
                state_next = igd_pkg::S_NN_ADD;
            end
            igd_pkg::S_NN_ADD: begin
                if (sq_a_reg + sq_b_reg < best_reg) best_next = sq_a_reg + sq_b_reg;
                if (j_reg + 1'b1 == ccnt_reg) begin
                    x_next = (2*SQ)'(best_next);
                    rs_next = '0;
                    k_next = SBC'(RT - 1);
                    state_next = igd_pkg::S_SQRT;
                end else begin
                    j_next = j_reg + 1'b1;
                    state_next = igd_pkg::S_NN_RD;
                end
            end
            igd_pkg::S_SQRT: begin
                // one root bit per cycle
                if (x_reg >= trial) begin
                    x_next = x_reg - trial;
                    rs_next = (rs_reg >> 1) | ((2*SQ)'(1) << {k_reg, 1'b0});
                end else begin
                    rs_next = rs_reg >> 1;
                end
                if (k_reg == '0) begin
                    sum_next = sum_reg + SB'(rs_next);
                    best_next = '1;
                    j_next = '0;
                    if (i_reg + 1'b1 == (RC+CC)'(rcnt_reg)) begin
                        state_next = igd_pkg::S_DIV_INIT;
                    end else begin
                        i_next = i_reg + 1'b1;
                        state_next = igd_pkg::S_NN_RD;
                    end
                end else begin
                    k_next = k_reg - 1'b1;
                end
            end
            igd_pkg::S_DIV_INIT: begin
                acc_next = '0;
                q_next = sum_reg;
                dv_next = DW'(rcnt_reg);
                k_next = SBC'(SB);
                state_next = igd_pkg::S_DIV;
            end
            igd_pkg::S_DIV: begin
                if (k_reg == '0) begin
                    m_item_next.igd_value = (q_reg > SB'(IGD_MAX)) ? IGD_MAX : IGD_W'(q_reg);
                    m_item_next.status = (cmax_reg <= cmin_reg || emax_reg <= emin_reg)
                                         ? igd_pkg::ST_ZERO_RANGE : igd_pkg::ST_OK;
                    state_next = igd_pkg::S_OUT;
                end else begin
                    k_next = k_reg - 1'b1;
                    acc_next = {acc_reg[DW-1:0], q_reg[SB-1]};
                    q_next = {q_reg[SB-2:0], 1'b0};
                    if ({acc_reg[DW-1:0], q_reg[SB-1]} >= {1'b0, dv_reg}) begin
                        acc_next = {acc_reg[DW-1:0], q_reg[SB-1]} - {1'b0, dv_reg};
                        q_next[0] = 1'b1;
                    end
                end
            end
            igd_pkg::S_OUT: begin
                m_item_next.points_dropped = ovf_reg;
                m_valid_next = 1'b1;
                ccnt_next = '0;
                ovf_next = 1'b0;
                state_next = igd_pkg::S_IDLE;
            end
            default: state_next = igd_pkg::S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_cnt_r: assert property (@(posedge aclk) disable iff (!aresetn)
        rcnt_reg <= RC'(MAX_REFERENCES)) else $error("reference count overflow");
    a_cnt_c: assert property (@(posedge aclk) disable iff (!aresetn)
        ccnt_reg <= CC'(MAX_CANDIDATES)) else $error("candidate count overflow");
    a_out_clr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == igd_pkg::S_OUT |=> m_valid_reg && ccnt_reg == '0 && !ovf_reg)
        else $error("result not posted");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != igd_pkg::S_IDLE |-> !s_ready) else $error("ready while busy");
`endif

endmodule

FILE: sim/inverted_generational_distance_tb.sv
// Self-checking testbench for the inverted generational distance block.
`timescale 1ns / 1ps
module inverted_generational_distance_tb;

    localparam int unsigned REF_DEPTH  = 256;
    localparam int unsigned CAND_DEPTH = 256;
    localparam int unsigned FRAC       = 16;
    localparam int unsigned ITEM_GOAL  = 950;
    localparam longint unsigned CYCLE_LIMIT = 4000000;
    localparam bit [igd_pkg::VALUE_BITS-1:0] ALL_ONES = '1;

    class igd_scoreboard;
        longint unsigned ref_cost[REF_DEPTH];
        longint unsigned ref_emis[REF_DEPTH];
        longint unsigned cand_cost[CAND_DEPTH];
        longint unsigned cand_emis[CAND_DEPTH];
        int unsigned ref_count;
        int unsigned cand_count;
        bit dropped_flag;
        igd_pkg::out_item_t pending_igd[$];
        int unsigned errors;
        int unsigned evals_checked;
        int unsigned status_hits[4];

        function new();
            ref_count = 0;
            cand_count = 0;
            dropped_flag = 0;
            errors = 0;
            evals_checked = 0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function longint unsigned scale_axis(longint unsigned v, longint unsigned lo,
                                             longint unsigned hi);
            longint unsigned a;
            longint unsigned d;
            if (hi <= lo) return 0;
            a = (v > lo) ? v - lo : 0;
            d = hi - lo;
            if (a > d) a = d;
            return (a << FRAC) / d;
        endfunction

        function longint unsigned root_floor(longint unsigned x);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'h4000_0000_0000_0000;
            while (bitv > x) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (x >= res + bitv) begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function igd_pkg::out_item_t predict_igd();
            igd_pkg::out_item_t o;
            longint unsigned cmin, cmax, emin, emax, sum, best, dc, de, sq;
            longint unsigned rnc, rne, cnc, cne, igd;
            int unsigned last;
            o.points_dropped = dropped_flag;
            if (cand_count == 0) begin
                o.igd_value = 17'(1 << FRAC);
                o.status = igd_pkg::ST_EMPTY_POP;
                return o;
            end
            if (ref_count == 0) begin
                o.igd_value = '0;
                o.status = igd_pkg::ST_NO_REF;
                return o;
            end
            last = ref_count - 1;
            cmin = ref_cost[0];
            cmax = ref_cost[last];
            emin = ref_emis[last];
            emax = ref_emis[0];
            for (int i = 0; i < ref_count; i++) begin
                if (ref_cost[i] < cmin) cmin = ref_cost[i];
                if (ref_cost[i] > cmax) cmax = ref_cost[i];
                if (ref_emis[i] < emin) emin = ref_emis[i];
                if (ref_emis[i] > emax) emax = ref_emis[i];
            end
            for (int i = 0; i < cand_count; i++) begin
                if (cand_cost[i] < cmin) cmin = cand_cost[i];
                if (cand_cost[i] > cmax) cmax = cand_cost[i];
                if (cand_emis[i] < emin) emin = cand_emis[i];
                if (cand_emis[i] > emax) emax = cand_emis[i];
            end
            sum = 0;
            for (int i = 0; i < ref_count; i++) begin
                rnc = scale_axis(ref_cost[i], cmin, cmax);
                rne = scale_axis(ref_emis[i], emin, emax);
                best = '1;
                for (int j = 0; j < cand_count; j++) begin
                    cnc = scale_axis(cand_cost[j], cmin, cmax);
                    cne = scale_axis(cand_emis[j], emin, emax);
                    dc = (cnc > rnc) ? cnc - rnc : rnc - cnc;
                    de = (cne > rne) ? cne - rne : rne - cne;
                    sq = dc * dc + de * de;
                    if (sq < best) best = sq;
                end
                sum += root_floor(best);
            end
            igd = sum / ref_count;
            if (igd > 131071) igd = 131071;
            o.igd_value = igd[igd_pkg::IGD_BITS-1:0];
            o.status = (cmax <= cmin || emax <= emin) ? igd_pkg::ST_ZERO_RANGE : igd_pkg::ST_OK;
            return o;
        endfunction

        function void note_input(igd_pkg::in_item_t it);
            case (it.operation)
                igd_pkg::OP_ADD_REF: begin
                    if (ref_count < REF_DEPTH) begin
                        ref_cost[ref_count] = it.cost_value;
                        ref_emis[ref_count] = it.emission_value;
                        ref_count++;
                    end else begin
                        dropped_flag = 1;
                    end
                end
                igd_pkg::OP_ADD_CAND: begin
                    if (cand_count < CAND_DEPTH) begin
                        cand_cost[cand_count] = it.cost_value;
                        cand_emis[cand_count] = it.emission_value;
                        cand_count++;
                    end else begin
                        dropped_flag = 1;
                    end
                end
                igd_pkg::OP_CLR_REF: ref_count = 0;
                default: begin
                    pending_igd = {pending_igd, predict_igd()};
                    cand_count = 0;
                    dropped_flag = 0;
                end
            endcase
        endfunction

        function void check_result(igd_pkg::out_item_t got);
            igd_pkg::out_item_t want;
            if (pending_igd.size() == 0) begin
                $display("%0t: unexpected result igd=%0d status=%0d dropped=%0d",
                         $time, got.igd_value, got.status, got.points_dropped);
                errors++;
                return;
            end
            want = pending_igd.pop_front();
            evals_checked++;
            status_hits[want.status]++;
            if (got.igd_value !== want.igd_value) begin
                $display("%0t: igd_value expected %0d actual %0d",
                         $time, want.igd_value, got.igd_value);
                errors++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                errors++;
            end
            if (got.points_dropped !== want.points_dropped) begin
                $display("%0t: points_dropped expected %0d actual %0d",
                         $time, want.points_dropped, got.points_dropped);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    igd_pkg::in_item_t s_item;
    logic m_valid;
    logic m_ready;
    igd_pkg::out_item_t m_item;

    igd_scoreboard sb;
    bit steady;
    int unsigned items_sent;
    longint unsigned cycles;

    inverted_generational_distance dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) m_ready <= steady || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_item);
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task send_item(input igd_pkg::op_t op, input bit [igd_pkg::VALUE_BITS-1:0] c,
                   input bit [igd_pkg::VALUE_BITS-1:0] e);
        igd_pkg::in_item_t it;
        it.operation = op;
        it.cost_value = c;
        it.emission_value = e;
        while (!steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        items_sent++;
        @(negedge aclk);
    endtask

    function bit [igd_pkg::VALUE_BITS-1:0] pick_value(input bit [igd_pkg::VALUE_BITS-1:0] base);
        case ($urandom_range(5))
            0: return '0;
            1: return ALL_ONES;
            2: return base + $urandom_range(7);
            3: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task eval_set(input int unsigned nref, input int unsigned ncand, input bit do_clear);
        bit [igd_pkg::VALUE_BITS-1:0] bc;
        bit [igd_pkg::VALUE_BITS-1:0] be;
        bit flat_c;
        bit flat_e;
        bc = $urandom;
        be = $urandom;
        flat_c = ($urandom_range(9) == 0);
        flat_e = ($urandom_range(9) == 0);
        if (do_clear) send_item(igd_pkg::OP_CLR_REF, $urandom, $urandom);
        for (int i = 0; i < nref; i++)
            send_item(igd_pkg::OP_ADD_REF, flat_c ? bc : pick_value(bc),
                      flat_e ? be : pick_value(be));
        for (int i = 0; i < ncand; i++)
            send_item(igd_pkg::OP_ADD_CAND, flat_c ? bc : pick_value(bc),
                      flat_e ? be : pick_value(be));
        send_item(igd_pkg::OP_EVAL, $urandom, $urandom);
    endtask

    initial begin
        sb = new();
        steady = 0;
        items_sent = 0;
        cycles = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty population, then no references.
        send_item(igd_pkg::OP_EVAL, '0, '0);
        send_item(igd_pkg::OP_ADD_CAND, ALL_ONES, '0);
        send_item(igd_pkg::OP_EVAL, ALL_ONES, ALL_ONES);
        // Extreme corners of the box.
        send_item(igd_pkg::OP_ADD_REF, '0, ALL_ONES);
        send_item(igd_pkg::OP_ADD_REF, ALL_ONES, '0);
        send_item(igd_pkg::OP_ADD_CAND, 32'h7fff_ffff, 32'h8000_0000);
        send_item(igd_pkg::OP_ADD_CAND, ALL_ONES, ALL_ONES);
        send_item(igd_pkg::OP_EVAL, '0, '0);
        // Empty population while references persist.
        send_item(igd_pkg::OP_EVAL, '0, '0);
        // Flat cost axis.
        send_item(igd_pkg::OP_CLR_REF, ALL_ONES, ALL_ONES);
        send_item(igd_pkg::OP_ADD_REF, 32'd5, 32'd7);
        send_item(igd_pkg::OP_ADD_REF, 32'd5, 32'd9);
        send_item(igd_pkg::OP_ADD_CAND, 32'd5, 32'd8);
        send_item(igd_pkg::OP_EVAL, '0, '0);
        // Both axes flat.
        send_item(igd_pkg::OP_CLR_REF, '0, '0);
        send_item(igd_pkg::OP_ADD_REF, ALL_ONES, ALL_ONES);
        send_item(igd_pkg::OP_ADD_CAND, ALL_ONES, ALL_ONES);
        send_item(igd_pkg::OP_EVAL, '0, '0);
        // Clear, then evaluate with a candidate but no references.
        send_item(igd_pkg::OP_CLR_REF, '0, '0);
        send_item(igd_pkg::OP_ADD_CAND, 32'd1, 32'd2);
        send_item(igd_pkg::OP_EVAL, '0, '0);

        // Overflow of each store, with the other store kept tiny.
        eval_set(REF_DEPTH + 1, 1, 1);
        eval_set(1, CAND_DEPTH + 1, 1);

        while (items_sent < ITEM_GOAL) begin
            steady = (items_sent >= 600 && items_sent < 760);
            if (items_sent >= 800 && items_sent < 820) begin
                // Hold off until every pending result has drained.
                while (sb.pending_igd.size() != 0) begin
                    s_valid <= 1'b0;
                    @(negedge aclk);
                end
            end
            if ($urandom_range(99) < 80)
                eval_set($urandom_range(6), $urandom_range(1, 6),
                         sb.ref_count > 12 || $urandom_range(2) == 0);
            else
                send_item(igd_pkg::op_t'($urandom_range(3)), $urandom, $urandom);
        end
        steady = 0;
        s_valid <= 1'b0;

        while (sb.pending_igd.size() != 0) @(negedge aclk);
        repeat (100) @(posedge aclk);

        $display("Sent %0d items, checked %0d evaluations (ok %0d, empty %0d, no-ref %0d,",
                 items_sent, sb.evals_checked, sb.status_hits[igd_pkg::ST_OK],
                 sb.status_hits[igd_pkg::ST_EMPTY_POP], sb.status_hits[igd_pkg::ST_NO_REF]);
        $display("zero-range %0d), including both store overflows.",
                 sb.status_hits[igd_pkg::ST_ZERO_RANGE]);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
